// ===== design/lpl_pkg.sv =====
// Package for the linked peak limiter: widths, register map, sequencer states
// and the control struct of the shared multiply-accumulate unit.
// No dependencies.
`default_nettype none

package lpl_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int NUM_CHANNELS = 2;
    localparam int ENV_BITS     = 28;
    localparam int THR_BITS     = 25;
    localparam int COEF_BITS    = 24;
    localparam int LGAIN_BITS   = 20;
    localparam int GAIN_BITS    = 17;
    localparam int MAG_BITS     = 43;
    localparam int MAC_A_BITS   = 28;
    localparam int MAC_B_BITS   = 24;
    localparam int PROD_BITS    = MAC_A_BITS + MAC_B_BITS;
    localparam int ACC_BITS     = 64;
    localparam int SPLIT_BITS   = 22;
    localparam int DIV_STEPS    = 16;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;

    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN     = 17'd65536;
    localparam logic                  RST_LIMITER_ON = 1'b1;
    localparam logic [THR_BITS-1:0]   RST_THRESHOLD  = 25'd16777216;
    localparam logic [COEF_BITS-1:0]  RST_RELEASE    = 24'd16777000;
    localparam logic [LGAIN_BITS-1:0] RST_IN_GAIN    = 20'd65536;
    localparam logic [LGAIN_BITS-1:0] RST_OUT_GAIN   = 20'd65536;
    localparam logic [1:0]            RST_ACTIVE_CH  = 2'd2;

    typedef enum logic [2:0] {
        REG_LIMITER_ON  = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_RELEASE     = 3'd2,
        REG_INPUT_GAIN  = 3'd3,
        REG_OUTPUT_GAIN = 3'd4,
        REG_ACTIVE_CH   = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_MAG_WB,
        ST_ENV,
        ST_ENV_WB,
        ST_GAIN,
        ST_DIV,
        ST_SCL_LO,
        ST_SCL_HI,
        ST_SCL_WB,
        ST_OUT_LO,
        ST_OUT_HI,
        ST_OUT_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accum;
        logic hi_shift;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== design/linked_peak_limiter.sv =====
// Linked peak limiter: in bypass a transaction goes straight to the done state; when
// limiting, each active channel (two or one) passes the magnitude, scaling and output
// states in turn, using a 16-step restoring divider and one shared 28x24 multiplier.
// Input is accepted only while idle; a full output register stalls the input.
// Reset is asynchronous, active low: registers take their reset values, envelope zero.
`default_nettype none

module linked_peak_limiter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample_ch0, sample_ch1
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // out_ch0, out_ch1, gain_applied, zero pad
    output logic      [0:0]  m_tuser    // saturated
);

    localparam int SB = lpl_pkg::SAMPLE_BITS;
    localparam int EB = lpl_pkg::ENV_BITS;
    localparam int MB = lpl_pkg::MAG_BITS;
    localparam int GB = lpl_pkg::GAIN_BITS;
    localparam int AB = lpl_pkg::ACC_BITS;
    localparam int SP = lpl_pkg::SPLIT_BITS;
    localparam int PK_SHIFT = SB - 9;

    // configuration
    logic                              limiter_on_reg;
    logic [lpl_pkg::THR_BITS-1:0]      threshold_reg;
    logic [lpl_pkg::COEF_BITS-1:0]     release_reg;
    logic [lpl_pkg::LGAIN_BITS-1:0]    in_gain_reg;
    logic [lpl_pkg::LGAIN_BITS-1:0]    out_gain_reg;
    logic [1:0]                        active_ch_reg;
    logic                              cfg_wr;
    logic                              two_ch;

    // sequencer and datapath
    lpl_pkg::state_t                   state_reg;
    lpl_pkg::state_t                   state_next;
    logic                              ch_reg;
    logic                              last_ch;
    logic [3:0]                        div_cnt_reg;
    logic [EB-1:0]                     env_reg;
    logic [EB-1:0]                     peak_reg;
    logic [EB-1:0]                     rem_reg;
    logic [GB-1:0]                     gain_reg;
    logic [MB-1:0]                     a_reg;
    logic [SB-1:0]                     abs_reg [2];
    logic                              neg_reg [2];
    logic [MB-1:0]                     mag_reg [2];
    logic [SB-1:0]                     res_reg [2];
    logic                              sat_reg;

    // output stage
    logic                              m_tvalid_reg;
    logic                              m_tvalid_next;
    logic [SB-1:0]                     m_ch0_reg;
    logic [SB-1:0]                     m_ch1_reg;
    logic [GB-1:0]                     m_gain_reg;
    logic                              m_sat_reg;
    logic                              out_free;

    // shared unit
    lpl_pkg::mac_ctl_t                 mac_ctl;
    logic [lpl_pkg::MAC_A_BITS-1:0]    mac_a;
    logic [lpl_pkg::MAC_B_BITS-1:0]    mac_b;
    logic [AB-1:0]                     acc;

    // arithmetic
    logic [SB-1:0]                     in_s0;
    logic [SB-1:0]                     in_s1;
    logic [MB-1:0]                     pk_sum;
    logic [EB-1:0]                     pk;
    logic [lpl_pkg::PROD_BITS-1:0]     env_sum;
    logic [EB-1:0]                     env_dec;
    logic [AB-1:0]                     scl_sum;
    logic [AB-1:0]                     out_sum;
    logic [31:0]                       r_val;
    logic                              r_clip;
    logic [SB-1:0]                     r_lim;
    logic [SB-1:0]                     r_out;
    logic [EB:0]                       rem_sh;
    logic                              div_ge;
    logic                              env_over;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign two_ch = (active_ch_reg >= 2'd2) && (lpl_pkg::NUM_CHANNELS >= 2);
    assign last_ch = !two_ch || ch_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limiter_on_reg <= lpl_pkg::RST_LIMITER_ON;
            threshold_reg  <= lpl_pkg::RST_THRESHOLD;
            release_reg    <= lpl_pkg::RST_RELEASE;
            in_gain_reg    <= lpl_pkg::RST_IN_GAIN;
            out_gain_reg   <= lpl_pkg::RST_OUT_GAIN;
            active_ch_reg  <= lpl_pkg::RST_ACTIVE_CH;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                lpl_pkg::REG_LIMITER_ON:  limiter_on_reg <= pwdata[0];
                lpl_pkg::REG_THRESHOLD:   threshold_reg  <= pwdata[lpl_pkg::THR_BITS-1:0];
                lpl_pkg::REG_RELEASE:     release_reg    <= pwdata[lpl_pkg::COEF_BITS-1:0];
                lpl_pkg::REG_INPUT_GAIN:  in_gain_reg    <= pwdata[lpl_pkg::LGAIN_BITS-1:0];
                lpl_pkg::REG_OUTPUT_GAIN: out_gain_reg   <= pwdata[lpl_pkg::LGAIN_BITS-1:0];
                lpl_pkg::REG_ACTIVE_CH:   active_ch_reg  <= pwdata[1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            lpl_pkg::REG_LIMITER_ON:  prdata = {31'd0, limiter_on_reg};
            lpl_pkg::REG_THRESHOLD:   prdata = {7'd0, threshold_reg};
            lpl_pkg::REG_RELEASE:     prdata = {8'd0, release_reg};
            lpl_pkg::REG_INPUT_GAIN:  prdata = {12'd0, in_gain_reg};
            lpl_pkg::REG_OUTPUT_GAIN: prdata = {12'd0, out_gain_reg};
            lpl_pkg::REG_ACTIVE_CH:   prdata = {30'd0, active_ch_reg};
            default:                  prdata = '0;
        endcase
    end

    lpl_mac u_mac
    (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    // arithmetic around the shared unit
    always_comb
    begin
        in_s0    = s_tdata[SB-1:0];
        in_s1    = s_tdata[2*SB-1:SB];
        pk_sum   = acc[MB-1:0] + (MB'(1) << (PK_SHIFT - 1));
        pk       = pk_sum[MB-1:PK_SHIFT];
        env_sum  = acc[lpl_pkg::PROD_BITS-1:0] + (lpl_pkg::PROD_BITS'(1) << 23);
        env_dec  = peak_reg + env_sum[lpl_pkg::PROD_BITS-1:24];
        scl_sum  = acc + (AB'(1) << 15);
        out_sum  = acc + (AB'(1) << 31);
        r_val    = out_sum[63:32];
        if (neg_reg[ch_reg])
        begin
            r_clip = r_val > 32'(1 << (SB - 1));
            r_lim  = r_clip ? SB'(1 << (SB - 1)) : r_val[SB-1:0];
            r_out  = SB'(0) - r_lim;
        end
        else
        begin
            r_clip = r_val > 32'((1 << (SB - 1)) - 1);
            r_lim  = r_clip ? SB'((1 << (SB - 1)) - 1) : r_val[SB-1:0];
            r_out  = r_lim;
        end
        rem_sh   = {rem_reg, 1'b0};
        div_ge   = rem_sh >= {1'b0, env_reg};
        env_over = env_reg > EB'(threshold_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = limiter_on_reg ? lpl_pkg::ST_MAG : lpl_pkg::ST_DONE;
                end
            end
            lpl_pkg::ST_MAG:    state_next = lpl_pkg::ST_MAG_WB;
            lpl_pkg::ST_MAG_WB: state_next = last_ch ? lpl_pkg::ST_ENV : lpl_pkg::ST_MAG;
            lpl_pkg::ST_ENV:
            begin
                state_next = (peak_reg > env_reg) ? lpl_pkg::ST_GAIN : lpl_pkg::ST_ENV_WB;
            end
            lpl_pkg::ST_ENV_WB: state_next = lpl_pkg::ST_GAIN;
            lpl_pkg::ST_GAIN:   state_next = env_over ? lpl_pkg::ST_DIV : lpl_pkg::ST_SCL_LO;
            lpl_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 4'(lpl_pkg::DIV_STEPS - 1))
                begin
                    state_next = lpl_pkg::ST_SCL_LO;
                end
            end
            lpl_pkg::ST_SCL_LO: state_next = lpl_pkg::ST_SCL_HI;
            lpl_pkg::ST_SCL_HI: state_next = lpl_pkg::ST_SCL_WB;
            lpl_pkg::ST_SCL_WB: state_next = lpl_pkg::ST_OUT_LO;
            lpl_pkg::ST_OUT_LO: state_next = lpl_pkg::ST_OUT_HI;
            lpl_pkg::ST_OUT_HI: state_next = lpl_pkg::ST_OUT_WB;
            lpl_pkg::ST_OUT_WB: state_next = last_ch ? lpl_pkg::ST_DONE : lpl_pkg::ST_SCL_LO;
            lpl_pkg::ST_DONE:   state_next = out_free ? lpl_pkg::ST_IDLE : lpl_pkg::ST_DONE;
            default:            state_next = lpl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        mac_ctl  = '0;
        mac_a    = '0;
        mac_b    = '0;
        unique case (state_reg)
            lpl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            lpl_pkg::ST_MAG:
            begin
                mac_a = lpl_pkg::MAC_A_BITS'(abs_reg[ch_reg]);
                mac_b = lpl_pkg::MAC_B_BITS'(in_gain_reg);
            end
            lpl_pkg::ST_ENV:
            begin
                mac_a = env_reg - peak_reg;
                mac_b = release_reg;
            end
            lpl_pkg::ST_SCL_LO:
            begin
                mac_a = lpl_pkg::MAC_A_BITS'(mag_reg[ch_reg][SP-1:0]);
                mac_b = lpl_pkg::MAC_B_BITS'(gain_reg);
            end
            lpl_pkg::ST_SCL_HI:
            begin
                mac_ctl = '{accum: 1'b1, hi_shift: 1'b1};
                mac_a   = lpl_pkg::MAC_A_BITS'(mag_reg[ch_reg][MB-1:SP]);
                mac_b   = lpl_pkg::MAC_B_BITS'(gain_reg);
            end
            lpl_pkg::ST_OUT_LO:
            begin
                mac_a = lpl_pkg::MAC_A_BITS'(a_reg[SP-1:0]);
                mac_b = lpl_pkg::MAC_B_BITS'(out_gain_reg);
            end
            lpl_pkg::ST_OUT_HI:
            begin
                mac_ctl = '{accum: 1'b1, hi_shift: 1'b1};
                mac_a   = lpl_pkg::MAC_A_BITS'(a_reg[MB-1:SP]);
                mac_b   = lpl_pkg::MAC_B_BITS'(out_gain_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpl_pkg::ST_IDLE;
            env_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == lpl_pkg::ST_ENV)
            begin
                if (peak_reg > env_reg)
                begin
                    env_reg <= peak_reg;
                end
            end
            else if (state_reg == lpl_pkg::ST_ENV_WB)
            begin
                env_reg <= env_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lpl_pkg::ST_IDLE:
            begin
                ch_reg     <= 1'b0;
                peak_reg   <= '0;
                sat_reg    <= 1'b0;
                gain_reg   <= lpl_pkg::UNITY_GAIN;
                neg_reg[0] <= in_s0[SB-1];
                neg_reg[1] <= in_s1[SB-1];
                abs_reg[0] <= in_s0[SB-1] ? SB'(0) - in_s0 : in_s0;
                abs_reg[1] <= in_s1[SB-1] ? SB'(0) - in_s1 : in_s1;
                res_reg[0] <= limiter_on_reg ? '0 : in_s0;
                res_reg[1] <= (limiter_on_reg || !two_ch) ? '0 : in_s1;
            end
            lpl_pkg::ST_MAG_WB:
            begin
                mag_reg[ch_reg] <= acc[MB-1:0];
                if (pk > peak_reg)
                begin
                    peak_reg <= pk;
                end
                if (!last_ch)
                begin
                    ch_reg <= 1'b1;
                end
            end
            lpl_pkg::ST_ENV:
            begin
                ch_reg <= 1'b0;
            end
            lpl_pkg::ST_GAIN:
            begin
                rem_reg     <= EB'(threshold_reg);
                div_cnt_reg <= '0;
                if (env_over)
                begin
                    gain_reg <= '0;
                end
            end
            lpl_pkg::ST_DIV:
            begin
                rem_reg     <= div_ge ? EB'(rem_sh - {1'b0, env_reg}) : rem_sh[EB-1:0];
                gain_reg    <= {gain_reg[GB-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            lpl_pkg::ST_SCL_WB:
            begin
                a_reg <= scl_sum[MB+15:16];
            end
            lpl_pkg::ST_OUT_WB:
            begin
                res_reg[ch_reg] <= r_out;
                sat_reg         <= sat_reg | r_clip;
                if (!last_ch)
                begin
                    ch_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (state_reg == lpl_pkg::ST_DONE && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lpl_pkg::ST_DONE && out_free)
        begin
            m_ch0_reg  <= res_reg[0];
            m_ch1_reg  <= res_reg[1];
            m_gain_reg <= gain_reg;
            m_sat_reg  <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_gain_reg, m_ch1_reg, m_ch0_reg};
    assign m_tuser  = m_sat_reg;

`ifndef SYNTH
    a_bypass_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !limiter_on_reg) |=> (state_reg == lpl_pkg::ST_DONE))
        else $error("bypass transaction did not go straight to output");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpl_pkg::ST_DIV) |-> (rem_reg < env_reg))
        else $error("divider remainder not below envelope");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[64:48] <= lpl_pkg::UNITY_GAIN))
        else $error("limiting gain above unity");
`endif

endmodule

`default_nettype wire

// ===== design/lpl_mac.sv =====
// Shared multiply-accumulate unit of the linked peak limiter.
// One 28x24 multiply per cycle, optional shift of the product and accumulate.
// Depends on lpl_pkg.
`default_nettype none

module lpl_mac
(
    input  wire logic                             clk,
    input  wire lpl_pkg::mac_ctl_t                ctl,
    input  wire logic [lpl_pkg::MAC_A_BITS-1:0]   op_a,
    input  wire logic [lpl_pkg::MAC_B_BITS-1:0]   op_b,
    output logic      [lpl_pkg::ACC_BITS-1:0]     acc
);

    localparam int SHIFT_KEEP = lpl_pkg::ACC_BITS - lpl_pkg::SPLIT_BITS;

    logic [lpl_pkg::PROD_BITS-1:0] prod;
    logic [lpl_pkg::ACC_BITS-1:0]  addend;
    logic [lpl_pkg::ACC_BITS-1:0]  base;
    logic [lpl_pkg::ACC_BITS-1:0]  acc_reg;

    always_comb
    begin
        prod = op_a * op_b;
        if (ctl.hi_shift)
        begin
            addend = {prod[SHIFT_KEEP-1:0], {lpl_pkg::SPLIT_BITS{1'b0}}};
        end
        else
        begin
            addend = {{(lpl_pkg::ACC_BITS-lpl_pkg::PROD_BITS){1'b0}}, prod};
        end
        base = ctl.accum ? acc_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= base + addend;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire
